### hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the cubic segment tessellator
// Segment record passed from the front end to the evaluator, register
// indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int MaxSamples = 64;
  localparam int CountW     = 7;
  localparam int KW         = $clog2(MaxSamples);

  // Configuration register indexes
  localparam logic [1:0] CFG_CURVE_MODE   = 2'd0;
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd1;

  // Curve modes
  localparam logic MODE_BSPLINE = 1'b0;
  localparam logic MODE_BEZIER  = 1'b1;

  localparam logic [CountW-1:0] CountReset = 7'd15;

  // ceil(2^22 / 3): exact floor division by 3 for operands below 2^21
  localparam logic [20:0] RECIP3 = 21'd1398102;
  // (2^20 - 1) / 3
  localparam logic [31:0] THIRD_2_20 = 32'd349525;

  typedef logic [3:0][2:0][31:0] ctrl_pts_t;

  typedef struct packed {
    ctrl_pts_t         pts;
    logic              mode;
    logic [16:0]       step_q;  // floor(65536 / count)
    logic [CountW-1:0] step_r;  // 65536 mod count
    logic [CountW-1:0] count;   // clamped sample count, 1..MaxSamples
  } seg_t;

endpackage

### hw/rtl/cst_front.sv
// ----------------------------------------------------------------------------
// cst_front: segment intake
// Takes one segment, clamps the sample count and derives the parameter
// step 65536 / count with a two-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module cst_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  cst_pkg::ctrl_pts_t        pts,
  input  logic                      mode,
  input  logic [cst_pkg::CountW-1:0] count_cfg,
  output logic                      push,
  output cst_pkg::seg_t             push_data,
  input  logic                      full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state, state_next;

  logic [17:0]                 dividend;
  logic [6:0]                  rem;
  logic [17:0]                 quo;
  logic [3:0]                  step_cnt;
  logic [cst_pkg::CountW-1:0]  count_clamped;
  logic [6:0]                  rem_next;
  logic [1:0]                  qbits;
  logic [7:0]                  r1;
  logic [7:0]                  r2;
  logic [7:0]                  cnt_ext;
  logic                        accept;
  cst_pkg::ctrl_pts_t          seg_pts;
  logic                        seg_mode;
  logic [cst_pkg::CountW-1:0]  seg_count;

  assign in_stall = (state != F_IDLE);
  assign accept   = in_valid && (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    if (count_cfg == '0) begin
      count_clamped = 7'd1;
    end else if (count_cfg > 7'(cst_pkg::MaxSamples)) begin
      count_clamped = 7'(cst_pkg::MaxSamples);
    end else begin
      count_clamped = count_cfg;
    end
  end

  // two restoring steps per cycle
  always_comb begin
    cnt_ext = {1'b0, seg_count};
    r1 = {rem, dividend[17]};
    qbits[1] = (r1 >= cnt_ext);
    if (qbits[1]) begin
      r1 = r1 - cnt_ext;
    end
    r2 = {r1[6:0], dividend[16]};
    qbits[0] = (r2 >= cnt_ext);
    if (qbits[0]) begin
      r2 = r2 - cnt_ext;
    end
    rem_next = r2[6:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          state_next = F_DIV;
        end
      end
      F_DIV: begin
        if (step_cnt == 4'd8) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seg_pts   <= pts;
      seg_mode  <= mode;
      seg_count <= count_clamped;
      dividend  <= 18'h10000;
      rem       <= '0;
      quo       <= '0;
      step_cnt  <= '0;
    end else if (state == F_DIV) begin
      dividend <= {dividend[15:0], 2'b00};
      rem      <= rem_next;
      quo      <= {quo[15:0], qbits};
      step_cnt <= step_cnt + 4'd1;
    end
  end

  assign push_data = {seg_pts, seg_mode, quo[16:0], rem, seg_count};

endmodule

### hw/rtl/cst_queue.sv
// ----------------------------------------------------------------------------
// cst_queue: two-entry segment queue
// Decouples segment intake from sample evaluation.
// ----------------------------------------------------------------------------
module cst_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cst_pkg::seg_t  push_data,
  output logic           full,
  input  logic           pop,
  output cst_pkg::seg_t  pop_data,
  output logic           nonempty
);

  cst_pkg::seg_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full     = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("queue fill out of range");

endmodule

### hw/rtl/cst_back.sv
// ----------------------------------------------------------------------------
// cst_back: sample evaluator
// Steps the parameter through a segment and runs a six-stage weight,
// product and normalize pipeline, one sample per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module cst_back (
  input  logic           clk,
  input  logic           rst,
  input  cst_pkg::seg_t  seg,
  input  logic           nonempty,
  output logic           pop,
  output logic [31:0]    out_x,
  output logic [31:0]    out_y,
  output logic [31:0]    out_z,
  output logic           last_sample,
  output logic           out_valid,
  input  logic           out_stall
);

  logic                       en;
  logic                       issue;
  logic                       last_k;
  logic [cst_pkg::KW-1:0]     k;
  logic [16:0]                t_acc;
  logic [6:0]                 rem_acc;
  logic [7:0]                 rem_sum;
  logic                       t_carry;
  logic [6:0]                 rem_wrap;

  // stage 1
  logic                       v1, m1, l1;
  logic [15:0]                t1;
  logic [16:0]                g1;
  cst_pkg::ctrl_pts_t         p1;
  logic [31:0]                tt1;
  logic [33:0]                gg1;
  // stage 2
  logic                       v2, m2, l2;
  logic [15:0]                t2r, tq2;
  logic [16:0]                g2r, gq2;
  cst_pkg::ctrl_pts_t         p2;
  logic [31:0]                t3m;
  logic [33:0]                g3m;
  logic [32:0]                am;
  logic [32:0]                bm;
  logic [34:0]                a3;
  logic [34:0]                b3;
  logic [15:0]                t3c;
  logic [16:0]                g3c;
  logic [20:0]                bs_w1, bs_w2;
  logic [3:0][19:0]           w_c;
  // stage 3
  logic                       v3, m3, l3;
  logic [3:0][19:0]           w3;
  cst_pkg::ctrl_pts_t         p3;
  logic signed [52:0]         prod_c [3][4];
  // stage 4
  logic                       v4, m4, l4;
  logic signed [52:0]         prod4 [3][4];
  logic signed [54:0]         acc_c [3];
  // stage 5
  logic                       v5, m5, l5;
  logic signed [54:0]         acc5 [3];
  logic [40:0]                u_c [3];
  logic [39:0]                vv_c [3];
  logic [40:0]                qh_m [3];
  // stage 6
  logic                       v6, m6, l6;
  logic [31:0]                bez6 [3];
  logic [18:0]                qh6 [3];
  logic [19:0]                vh6 [3];
  logic [19:0]                vl6 [3];
  logic [19:0]                rh_w [3];
  logic [20:0]                xs [3];
  logic [41:0]                qx_m [3];
  logic [31:0]                res_c [3];

  assign en     = !out_valid || !out_stall;
  assign issue  = nonempty && en;
  assign last_k = (7'(k) == seg.count - 7'd1);
  assign pop    = issue && last_k;

  // parameter stepping: t = q*k + floor(r*k / count)
  always_comb begin
    rem_sum  = 8'(rem_acc) + 8'(seg.step_r);
    t_carry  = (rem_sum >= {1'b0, seg.count});
    rem_wrap = t_carry ? 7'(rem_sum - {1'b0, seg.count}) : rem_sum[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k       <= '0;
      t_acc   <= '0;
      rem_acc <= '0;
    end else if (issue) begin
      if (last_k) begin
        k       <= '0;
        t_acc   <= '0;
        rem_acc <= '0;
      end else begin
        k       <= k + {{(cst_pkg::KW-1){1'b0}}, 1'b1};
        t_acc   <= t_acc + seg.step_q + 17'(t_carry);
        rem_acc <= rem_wrap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= issue; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
      out_valid <= v6;
    end
  end

  // stage 1 -> 2: squares
  assign tt1 = t1 * t1;
  assign gg1 = g1 * g1;

  // stage 2 -> 3: cubes and weights
  always_comb begin
    t3m   = tq2 * t2r;
    g3m   = gq2 * g2r;
    am    = gq2 * tq2;
    bm    = g2r * t2r;
    a3    = 35'(am) + 35'({am, 1'b0});
    b3    = 35'(bm) + 35'({bm, 1'b0});
    t3c   = t3m[31:16];
    g3c   = g3m[32:16];
    bs_w1 = 21'(3 * 21'(t3c)) - 21'(6 * 21'(t2r)) + 21'h40000;
    bs_w2 = 21'(3 * 21'(tq2)) - 21'(3 * 21'(t3c)) + 21'(3 * 21'(t2r)) + 21'h10000;
    w_c[0] = 20'(g3c);
    w_c[3] = 20'(t3c);
    if (m2 == cst_pkg::MODE_BEZIER) begin
      w_c[1] = 20'(a3[34:16]);
      w_c[2] = 20'(b3[34:16]);
    end else begin
      w_c[1] = bs_w1[19:0];
      w_c[2] = bs_w2[19:0];
    end
  end

  // stage 3 -> 4: products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 4; i++) begin
        prod_c[c][i] = $signed(p3[i][c]) * $signed({1'b0, w3[i]});
      end
    end
  end

  // stage 4 -> 5: sums
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_c[c] = 55'(prod4[c][0]) + 55'(prod4[c][1]) + 55'(prod4[c][2])
               + 55'(prod4[c][3]);
    end
  end

  // stage 5 -> 6: floor by 65536, offset positive and halve, then split for /3
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      u_c[c]  = 41'($signed(acc5[c][54:16])) + (41'd6 << 38);
      vv_c[c] = u_c[c][40:1];
      qh_m[c] = vv_c[c][39:20] * cst_pkg::RECIP3;
    end
  end

  // stage 6 -> out: finish division by 3
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rh_w[c]  = vh6[c] - 20'(3 * 20'(qh6[c]));
      xs[c]    = 21'(vl6[c]) + 21'(rh_w[c][1:0]);
      qx_m[c]  = xs[c] * cst_pkg::RECIP3;
      res_c[c] = 32'({qh6[c], 20'b0}) + 32'(rh_w[c][1:0]) * cst_pkg::THIRD_2_20
               + 32'(qx_m[c][41:22]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t_acc[15:0];
      g1 <= 17'h10000 - t_acc;
      p1 <= seg.pts;
      m1 <= seg.mode;
      l1 <= last_k;

      tq2 <= t1;
      g2r <= g1;
      t2r <= tt1[31:16];
      gq2 <= gg1[32:16];
      p2  <= p1;
      m2  <= m1;
      l2  <= l1;

      w3 <= w_c;
      p3 <= p2;
      m3 <= m2;
      l3 <= l2;

      prod4 <= prod_c;
      m4    <= m3;
      l4    <= l3;

      acc5 <= acc_c;
      m5   <= m4;
      l5   <= l4;

      for (int c = 0; c < 3; c++) begin
        bez6[c] <= acc5[c][47:16];
        qh6[c]  <= qh_m[c][40:22];
        vh6[c]  <= vv_c[c][39:20];
        vl6[c]  <= vv_c[c][19:0];
      end
      m6 <= m5;
      l6 <= l5;

      if (m6 == cst_pkg::MODE_BEZIER) begin
        out_x <= bez6[0];
        out_y <= bez6[1];
        out_z <= bez6[2];
      end else begin
        out_x <= res_c[0];
        out_y <= res_c[1];
        out_z <= res_c[2];
      end
      last_sample <= l6;
    end
  end

endmodule

### hw/rtl/cubic_segment_tessellator_unit.sv
// ----------------------------------------------------------------------------
// cubic_segment_tessellator_unit: cubic Bezier / uniform B-spline tessellator
// Takes a segment of four 3D control points and emits the clamped sample_count
// (1..64) curve points at t = floor(k*65536/count), flagging the last one.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_stall  | ctrl0_x .. ctrl3_z, Q16.16 signed
//   out     | out_valid / out_stall| out_x, out_y, out_z, last_sample
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Intake accepts a segment, runs the divider and pushes it once the queue has
// room. The evaluator emits one sample per cycle while out_stall is low,
// each through its pipeline stages and the output register.
// Reset (synchronous, rst high) empties the queue and pipeline and sets
// curve_mode to B-spline and sample_count to 15.
// out_stall holds the whole evaluator; the two-entry queue lets intake go on.
// ----------------------------------------------------------------------------
module cubic_segment_tessellator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] ctrl0_x,
  input  logic [31:0] ctrl0_y,
  input  logic [31:0] ctrl0_z,
  input  logic [31:0] ctrl1_x,
  input  logic [31:0] ctrl1_y,
  input  logic [31:0] ctrl1_z,
  input  logic [31:0] ctrl2_x,
  input  logic [31:0] ctrl2_y,
  input  logic [31:0] ctrl2_z,
  input  logic [31:0] ctrl3_x,
  input  logic [31:0] ctrl3_y,
  input  logic [31:0] ctrl3_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic        last_sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic                       curve_mode;
  logic [cst_pkg::CountW-1:0] sample_count;
  cst_pkg::ctrl_pts_t         pts;
  cst_pkg::seg_t              push_data;
  cst_pkg::seg_t              pop_data;
  logic                       push, pop, full, nonempty;

  // Registers take every transaction; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode   <= cst_pkg::MODE_BSPLINE;
      sample_count <= cst_pkg::CountReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        cst_pkg::CFG_CURVE_MODE:   curve_mode   <= cfg_data[0];
        cst_pkg::CFG_SAMPLE_COUNT: sample_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pack control points as [point][axis].
  assign pts[0][0] = ctrl0_x; assign pts[0][1] = ctrl0_y; assign pts[0][2] = ctrl0_z;
  assign pts[1][0] = ctrl1_x; assign pts[1][1] = ctrl1_y; assign pts[1][2] = ctrl1_z;
  assign pts[2][0] = ctrl2_x; assign pts[2][1] = ctrl2_y; assign pts[2][2] = ctrl2_z;
  assign pts[3][0] = ctrl3_x; assign pts[3][1] = ctrl3_y; assign pts[3][2] = ctrl3_z;

  cst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pts       (pts),
    .mode      (curve_mode),
    .count_cfg (sample_count),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  cst_back u_back (
    .clk         (clk),
    .rst         (rst),
    .seg         (pop_data),
    .nonempty    (nonempty),
    .pop         (pop),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cubic_segment_tessellator_unit
// Drives curve segments and register writes, computes every curve sample
// in a local fixed-point model of both bases and checks the output stream
// in order, with random idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  // register indexes outside the list; writes there must be ignored
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [31:0] x, y, z;
    logic        last;
  } curve_pt_t;

  // Predicts curve samples per accepted segment and checks them in order.
  class sample_board;
    curve_pt_t pending_pts[$];
    logic      mode;
    logic [6:0] count_reg;
    int        errors;

    function new();
      mode = cst_pkg::MODE_BSPLINE;
      count_reg = cst_pkg::CountReset;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] data);
      if (idx == cst_pkg::CFG_CURVE_MODE) mode = data[0];
      else if (idx == cst_pkg::CFG_SAMPLE_COUNT) count_reg = data;
    endfunction

    function longint fdiv(longint a, longint d);
      if (a >= 0) return a / d;
      return -((-a + d - 1) / d);
    endfunction

    // Expand one segment into its samples.
    function void note_segment(cst_pkg::ctrl_pts_t p);
      longint cnt, t, g, t2, t3, g2, g3, dv, acc;
      longint w[4];
      curve_pt_t s;
      logic [31:0] coord[3];
      cnt = count_reg;
      if (cnt == 0) cnt = 1;
      if (cnt > cst_pkg::MaxSamples) cnt = cst_pkg::MaxSamples;
      for (longint k = 0; k < cnt; k++) begin
        t  = (k * 65536) / cnt;
        g  = 65536 - t;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        g2 = (g * g) >>> 16;
        g3 = (g2 * g) >>> 16;
        w[0] = g3;
        w[3] = t3;
        if (mode == cst_pkg::MODE_BEZIER) begin
          w[1] = (3 * g2 * t) >>> 16;
          w[2] = (3 * g * t2) >>> 16;
          dv = 65536;
        end else begin
          w[1] = 3 * t3 - 6 * t2 + 4 * 65536;
          w[2] = -3 * t3 + 3 * t2 + 3 * t + 65536;
          dv = 6 * 65536;
        end
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int i = 0; i < 4; i++)
            acc += longint'($signed(p[i][c])) * w[i];
          coord[c] = 32'(fdiv(acc, dv));
        end
        s.x = coord[0];
        s.y = coord[1];
        s.z = coord[2];
        s.last = (k == cnt - 1);
        pending_pts = {pending_pts, s};
      end
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
      curve_pt_t e;
      if (pending_pts.size() == 0) begin
        report($sformatf("unexpected sample %h %h %h", x, y, z));
        return;
      end
      e = pending_pts.pop_front();
      if (x !== e.x) report($sformatf("out_x %h, want %h", x, e.x));
      if (y !== e.y) report($sformatf("out_y %h, want %h", y, e.y));
      if (z !== e.z) report($sformatf("out_z %h, want %h", z, e.z));
      if (last !== e.last) report($sformatf("last_sample %b, want %b", last, e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cst_pkg::ctrl_pts_t seg_drv = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x, out_y, out_z;
  logic        last_sample;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  sample_board board = new();
  bit quiet    = 0;  // no idling on either side
  bit hold_req = 0;  // ask the receiver for one long hold-off
  int cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cubic_segment_tessellator_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .ctrl0_x(seg_drv[0][0]), .ctrl0_y(seg_drv[0][1]), .ctrl0_z(seg_drv[0][2]),
    .ctrl1_x(seg_drv[1][0]), .ctrl1_y(seg_drv[1][1]), .ctrl1_z(seg_drv[1][2]),
    .ctrl2_x(seg_drv[2][0]), .ctrl2_y(seg_drv[2][1]), .ctrl2_z(seg_drv[2][2]),
    .ctrl3_x(seg_drv[3][0]), .ctrl3_y(seg_drv[3][1]), .ctrl3_z(seg_drv[3][2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .last_sample(last_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watchdog: end the run if the block hangs.
  initial forever begin
    @(posedge clk);
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: check at the rising edge, pick the next stall at the falling edge.
  initial begin
    int burst, hold;
    burst = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.check_sample(out_x, out_y, out_z, last_sample);
      @(negedge clk);
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold > 0) begin
        // long hold-off: let the queue fill so intake backs up
        hold--;
        out_stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 5) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one segment; hold the payload until the transaction completes.
  task send_segment(cst_pkg::ctrl_pts_t p);
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 5)) @(negedge clk);
    seg_drv = p;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_segment(p);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Register write; only issued while the block is idle.
  task write_cfg(logic [1:0] idx, logic [6:0] data);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every outstanding sample, then let the pipeline settle.
  task drain();
    while (board.pending_pts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function cst_pkg::ctrl_pts_t rand_segment();
    cst_pkg::ctrl_pts_t p;
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 3; c++)
        p[i][c] = rand_coord();
    return p;
  endfunction

  function cst_pkg::ctrl_pts_t fill_segment(logic [31:0] v);
    cst_pkg::ctrl_pts_t p;
    for (int i = 0; i < 4; i++)
      for (int c = 0; c < 3; c++)
        p[i][c] = v;
    return p;
  endfunction

  initial begin
    cst_pkg::ctrl_pts_t p;
    int n_items;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset settings first, extreme coordinates.
    send_segment(fill_segment(32'h0000_0000));
    send_segment(fill_segment(32'h7fff_ffff));
    send_segment(fill_segment(32'h8000_0000));
    send_segment(fill_segment(32'hffff_ffff));
    p = fill_segment(32'h7fff_ffff);
    p[1] = {3{32'h8000_0000}};
    p[3] = {3{32'h8000_0000}};
    send_segment(p);
    drain();

    // Bezier, single sample.
    write_cfg(cst_pkg::CFG_CURVE_MODE, {6'd0, cst_pkg::MODE_BEZIER});
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd1);
    send_segment(p);
    send_segment(rand_segment());
    drain();
    // zero count behaves as one sample
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd0);
    send_segment(fill_segment(32'h8000_0000));
    send_segment(rand_segment());
    drain();
    // largest count, then a count that saturates
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd64);
    send_segment(fill_segment(32'h7fff_ffff));
    send_segment(rand_segment());
    drain();
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd127);
    send_segment(p);
    drain();
    // writes to unused indexes change nothing
    write_cfg(CFG_SPARE_A, 7'h7f);
    write_cfg(CFG_SPARE_B, 7'h00);
    send_segment(rand_segment());
    drain();
    write_cfg(cst_pkg::CFG_CURVE_MODE, {6'd0, cst_pkg::MODE_BSPLINE});
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd64);
    send_segment(p);
    send_segment(fill_segment(32'h8000_0000));
    drain();
    write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'd2);
    send_segment(rand_segment());
    send_segment(rand_segment());
    drain();

    // Random phases, each with its own settings.
    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph == 11);
      write_cfg(cst_pkg::CFG_CURVE_MODE, {6'd0, 1'($urandom_range(0, 1))});
      if ($urandom_range(0, 4) == 0)
        write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'($urandom_range(0, 127)));
      else
        write_cfg(cst_pkg::CFG_SAMPLE_COUNT, 7'($urandom_range(1, 16)));
      if (ph == 3) hold_req = 1;
      n_items = $urandom_range(35, 45);
      for (int i = 0; i < n_items; i++) begin
        send_segment(rand_segment());
        // mid-phase: pause until the output side has caught up
        if (ph == 5 && i == n_items / 2)
          while (board.pending_pts.size() != 0) @(negedge clk);
      end
      drain();
    end

    if (board.errors == 0 && board.pending_pts.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
